[rtl/core/bsl_pkg.sv]
// Shared types and constants for the BAT service list parser.
// No dependencies; imported by bsl_parse, bsl_outbuf and the top level.
package bsl_pkg;

    localparam logic [7:0] SERVICE_LIST_TAG  = 8'h41;
    localparam logic [7:0] PRIVATE_TAG_RESET = 8'h86;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 72;

    // one service entry as it leaves the parser
    typedef struct packed {
        logic        kind_known;
        logic [7:0]  service_kind;
        logic [15:0] service;
        logic [15:0] network;
        logic [15:0] transport_stream;
        logic [15:0] out_bouquet;
    } bsl_result_t;

endpackage

[rtl/core/bsl_parse.sv]
// Byte-wise walker of the nested length-counted loops of a BAT body.
// Depends on bsl_pkg; each accepted byte updates the registered state.
module bsl_parse
    import bsl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        accept,
    input  logic [7:0]  section_byte,
    input  logic        section_start,
    input  logic [15:0] bouquet_ident,
    output logic        res_valid,
    output bsl_result_t res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_BQ_LEN_LO,
        PH_BQ_TAG,
        PH_BQ_LEN,
        PH_BQ_BODY,
        PH_TS_LEN_HI,
        PH_TS_LEN_LO,
        PH_TS_HDR,
        PH_TD_TAG,
        PH_TD_LEN,
        PH_TD_BODY,
        PH_DONE
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [11:0] outer_reg,    outer_next;
    logic [11:0] inner_reg,    inner_next;
    logic [7:0]  tag_reg,      tag_next;
    logic [7:0]  drem_reg,     drem_next;
    logic [2:0]  idx_reg,      idx_next;
    logic [47:0] bytes_reg,    bytes_next;
    logic [15:0] cur_ts_reg,   cur_ts_next;
    logic [15:0] cur_net_reg,  cur_net_next;
    logic [15:0] bouquet_reg,  bouquet_next;
    logic [7:0]  priv_tag_reg;

    logic        in_td;
    logic [47:0] shifted;
    logic [2:0]  idx_inc;
    logic [11:0] loop_dec;
    logic [11:0] outer_dec;
    logic [7:0]  drem_dec;
    logic [11:0] len_full;
    logic        tag_match;
    logic [2:0]  entry_len;

    always_comb begin
        in_td     = (phase_reg == PH_TD_TAG) || (phase_reg == PH_TD_LEN)
                    || (phase_reg == PH_TD_BODY);
        shifted   = {bytes_reg[39:0], section_byte};
        idx_inc   = idx_reg + 3'd1;
        outer_dec = outer_reg - 12'd1;
        loop_dec  = (in_td ? inner_reg : outer_reg) - 12'd1;
        drem_dec  = drem_reg - 8'd1;
        len_full  = {inner_reg[11:8], section_byte};
        tag_match = in_td ? (tag_reg == SERVICE_LIST_TAG) : (tag_reg == priv_tag_reg);
        entry_len = in_td ? 3'd3 : 3'd6;

        phase_next   = phase_reg;
        outer_next   = outer_reg;
        inner_next   = inner_reg;
        tag_next     = tag_reg;
        drem_next    = drem_reg;
        idx_next     = idx_reg;
        bytes_next   = bytes_reg;
        cur_ts_next  = cur_ts_reg;
        cur_net_next = cur_net_reg;
        bouquet_next = bouquet_reg;

        res_valid            = 1'b0;
        res.out_bouquet      = bouquet_reg;
        res.transport_stream = cur_ts_reg;
        res.network          = cur_net_reg;
        res.service          = shifted[23:8];
        res.service_kind     = shifted[7:0];
        res.kind_known       = 1'b1;

        if (accept) begin
            if (section_start) begin
                // restart at the bouquet descriptors length, dropping any work
                bouquet_next = bouquet_ident;
                inner_next   = {section_byte[3:0], 8'h00};
                outer_next   = '0;
                tag_next     = '0;
                drem_next    = '0;
                idx_next     = '0;
                bytes_next   = '0;
                cur_ts_next  = '0;
                cur_net_next = '0;
                phase_next   = PH_BQ_LEN_LO;
            end else begin
                unique case (phase_reg)
                    PH_BQ_LEN_LO: begin
                        outer_next = len_full;
                        inner_next = '0;
                        phase_next = (len_full != 12'd0) ? PH_BQ_TAG : PH_TS_LEN_HI;
                    end
                    PH_BQ_TAG, PH_BQ_LEN, PH_BQ_BODY,
                    PH_TD_TAG, PH_TD_LEN, PH_TD_BODY: begin
                        if (in_td) begin
                            inner_next = loop_dec;
                            outer_next = outer_dec;
                        end else begin
                            outer_next = loop_dec;
                        end
                        if (phase_reg == PH_BQ_TAG || phase_reg == PH_TD_TAG) begin
                            tag_next   = section_byte;
                            phase_next = in_td ? PH_TD_LEN : PH_BQ_LEN;
                        end else if (phase_reg == PH_BQ_LEN || phase_reg == PH_TD_LEN) begin
                            drem_next  = section_byte;
                            idx_next   = '0;
                            bytes_next = '0;
                            if (section_byte != 8'd0)
                                phase_next = in_td ? PH_TD_BODY : PH_BQ_BODY;
                            else
                                phase_next = in_td ? PH_TD_TAG : PH_BQ_TAG;
                        end else begin
                            drem_next = drem_dec;
                            if (tag_match) begin
                                bytes_next = shifted;
                                idx_next   = idx_inc;
                                if (idx_inc >= entry_len) begin
                                    res_valid  = 1'b1;
                                    idx_next   = '0;
                                    bytes_next = '0;
                                    if (!in_td) begin
                                        res.transport_stream = shifted[47:32];
                                        res.network          = shifted[31:16];
                                        res.service          = shifted[15:0];
                                        res.service_kind     = 8'h00;
                                        res.kind_known       = 1'b0;
                                    end
                                end
                            end
                            if (drem_dec != 8'd0)
                                phase_next = in_td ? PH_TD_BODY : PH_BQ_BODY;
                            else
                                phase_next = in_td ? PH_TD_TAG : PH_BQ_TAG;
                        end
                        // loop end clips the descriptor
                        if (loop_dec == 12'd0) begin
                            if (in_td) begin
                                idx_next   = '0;
                                bytes_next = '0;
                                phase_next = PH_TS_HDR;
                            end else begin
                                phase_next = PH_TS_LEN_HI;
                            end
                        end
                        if (in_td && outer_dec == 12'd0)
                            phase_next = PH_DONE;
                    end
                    PH_TS_LEN_HI: begin
                        inner_next = {section_byte[3:0], 8'h00};
                        phase_next = PH_TS_LEN_LO;
                    end
                    PH_TS_LEN_LO: begin
                        outer_next = len_full;
                        inner_next = '0;
                        idx_next   = '0;
                        bytes_next = '0;
                        phase_next = (len_full != 12'd0) ? PH_TS_HDR : PH_DONE;
                    end
                    PH_TS_HDR: begin
                        outer_next = outer_dec;
                        bytes_next = shifted;
                        idx_next   = idx_inc;
                        if (idx_inc >= 3'd6) begin
                            cur_ts_next  = shifted[47:32];
                            cur_net_next = shifted[31:16];
                            inner_next   = shifted[11:0];
                            idx_next     = '0;
                            bytes_next   = '0;
                            phase_next   = (shifted[11:0] != 12'd0) ? PH_TD_TAG : PH_TS_HDR;
                        end
                        if (outer_dec == 12'd0)
                            phase_next = PH_DONE;
                    end
                    default: begin
                        // idle or past the transport loop: bytes ignored
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            priv_tag_reg <= PRIVATE_TAG_RESET;
        end else begin
            phase_reg <= phase_next;
            if (cfg_wr_en)
                priv_tag_reg <= cfg_wr_data;
        end
        outer_reg   <= outer_next;
        inner_reg   <= inner_next;
        tag_reg     <= tag_next;
        drem_reg    <= drem_next;
        idx_reg     <= idx_next;
        bytes_reg   <= bytes_next;
        cur_ts_reg  <= cur_ts_next;
        cur_net_reg <= cur_net_next;
        bouquet_reg <= bouquet_next;
    end

endmodule

[rtl/core/bsl_outbuf.sv]
// Output register with a skid stage for the service entries.
// Depends on bsl_pkg for the result type.
module bsl_outbuf
    import bsl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  bsl_result_t in_data,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output bsl_result_t out_data
);

    logic        main_valid_reg;
    logic        skid_valid_reg;
    bsl_result_t main_reg;
    bsl_result_t skid_reg;
    logic        main_free;

    assign main_free = !main_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            // skid holds the older item, so it goes first
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
        if (main_free)
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        else if (in_valid)
            skid_reg <= in_data;
    end

endmodule

[rtl/core/bat_service_list_parser_top.sv]
// Top level of the BAT service list parser: stream ports and config register.
// Depends on bsl_pkg, bsl_parse and bsl_outbuf.
//
// Section body bytes go in one item per clock while s_tready is high; the loop
// walker takes each item as it arrives, so the block sustains one byte per cycle
// with no stalls of its own. The byte that completes a service entry loads it into
// the output register, or into the skid stage while the master side stalls. The
// output register has a one-entry skid stage, so s_tready only drops after the
// master side has stalled with two entries held. Write private_list_tag through
// cfg_wr_en/cfg_wr_data while no section is in progress; it resets to 0x86.
module bat_service_list_parser_top
    import bsl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // section_byte[7:0], bouquet_ident[23:8]
    input  logic                 s_tuser,  // section_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_bouquet[15:0], transport_stream[31:16],
                                           // network[47:32], service[63:48],
                                           // service_kind[71:64]
    output logic                 m_tuser   // kind_known
);

    logic        accept;
    logic        res_valid;
    bsl_result_t res;
    bsl_result_t out_res;

    assign accept = s_tvalid && s_tready;

    bsl_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .accept        (accept),
        .section_byte  (s_tdata[7:0]),
        .section_start (s_tuser),
        .bouquet_ident (s_tdata[23:8]),
        .res_valid     (res_valid),
        .res           (res)
    );

    bsl_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.service_kind, out_res.service, out_res.network,
                      out_res.transport_stream, out_res.out_bouquet};
    assign m_tuser = out_res.kind_known;

endmodule

[rtl/core/bsl_checker.sv]
// Port-level checks for the BAT service list parser, bound to the top level.
// Depends only on the top level's port list.
module bsl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser
);

    // a stalled entry stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled entry changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("entry offered straight after reset");

    // back-pressure only once the output register is occupied
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // no entry from nothing, and none from a section start item
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && (!(s_tvalid && s_tready) || s_tuser) |=> !m_tvalid)
        else $error("entry appeared without a completing byte");

endmodule

bind bat_service_list_parser_top bsl_checker u_bsl_checker (.*);

[tb/bat_service_list_parser_top_tb.sv]
// Self-checking bench for bat_service_list_parser_top: random BAT section bodies in,
// predicted service entries compared against the master side, field by field.
// Depends on bsl_pkg and the parser RTL only.
module bat_service_list_parser_top_tb;
    import bsl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 200;

    localparam logic [7:0] INTRO_BYTES [27] = '{
        8'hA5,                                           // ahead of any start: ignored
        8'hF0, 8'h09,                                    // reserved bits set, loop of 9
        PRIVATE_TAG_RESET, 8'h06, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34,
        SERVICE_LIST_TAG,                                // tag as last byte of the loop
        8'hF0, 8'h0C,                                    // transport loop of 12
        8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 8'h05,        // header, reserved bits set
        SERVICE_LIST_TAG, 8'h03, 8'hFF, 8'hFF, 8'hFF,
        8'h00,                                           // header cut by the loop end
        8'h77                                            // trailing, ignored
    };

    typedef enum logic [3:0] {
        W_IDLE, W_BQ_LEN_LO, W_BQ_DESC, W_TS_LEN_HI, W_TS_LEN_LO, W_TS_HDR, W_TD_DESC, W_DONE
    } walk_phase_t;

    typedef enum logic [1:0] { D_TAG, D_LEN, D_BODY } desc_step_t;

    typedef struct packed {
        logic [15:0] bouquet;
        logic        start;
        logic [7:0]  sbyte;
    } feed_item_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [7:0]           cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    feed_item_t  byte_feed[$];
    bsl_result_t pending_services[$];
    logic [7:0]  sec_buf[$];
    feed_item_t  next_item;

    int  fail_cnt    = 0;
    int  cycle_cnt   = 0;
    int  src_wait    = 0;
    int  sink_wait   = 0;
    int  sink_draw;
    int  phase_items;
    bit  src_calm    = 1'b0;
    bit  sink_calm   = 1'b0;
    logic [7:0] tag_plan [5];

    // parser image
    logic [7:0]  list_tag   = PRIVATE_TAG_RESET;
    walk_phase_t walk_phase = W_IDLE;
    desc_step_t  desc_step  = D_TAG;
    logic [11:0] outer_left = '0;
    logic [11:0] inner_left = '0;
    logic [7:0]  img_tag    = '0;
    logic [7:0]  desc_left  = '0;
    logic [2:0]  ent_cnt    = '0;
    logic [47:0] ent_buf    = '0;
    logic [15:0] cur_ts     = '0;
    logic [15:0] cur_net    = '0;
    logic [15:0] held_bq    = '0;

    bat_service_list_parser_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void queue_service(input logic [15:0] ts, input logic [15:0] net,
                                          input logic [15:0] svc, input logic [7:0] kind,
                                          input logic known);
        bsl_result_t r;
        r.out_bouquet      = held_bq;
        r.transport_stream = ts;
        r.network          = net;
        r.service          = svc;
        r.service_kind     = kind;
        r.kind_known       = known;
        pending_services.push_back(r);
    endfunction

    // one byte of a descriptor loop, counted against loop_left
    task automatic walk_descriptor_byte(input logic [7:0] b, input logic in_ts,
                                        inout logic [11:0] loop_left);
        loop_left = loop_left - 12'd1;
        case (desc_step)
            D_TAG: begin
                img_tag   = b;
                desc_step = D_LEN;
            end
            D_LEN: begin
                desc_left = b;
                ent_cnt   = '0;
                ent_buf   = '0;
                desc_step = (b != 8'd0) ? D_BODY : D_TAG;
            end
            default: begin
                desc_left = desc_left - 8'd1;
                if (in_ts && img_tag == SERVICE_LIST_TAG) begin
                    ent_buf = {ent_buf[39:0], b};
                    ent_cnt = ent_cnt + 3'd1;
                    if (ent_cnt >= 3'd3) begin
                        queue_service(cur_ts, cur_net, ent_buf[23:8], ent_buf[7:0], 1'b1);
                        ent_cnt = '0;
                        ent_buf = '0;
                    end
                end else if (!in_ts && img_tag == list_tag) begin
                    ent_buf = {ent_buf[39:0], b};
                    ent_cnt = ent_cnt + 3'd1;
                    if (ent_cnt >= 3'd6) begin
                        queue_service(ent_buf[47:32], ent_buf[31:16], ent_buf[15:0],
                                      8'h00, 1'b0);
                        ent_cnt = '0;
                        ent_buf = '0;
                    end
                end
                desc_step = (desc_left != 8'd0) ? D_BODY : D_TAG;
            end
        endcase
    endtask

    task automatic walk_section_byte(input logic [7:0] b, input logic start,
                                     input logic [15:0] bq);
        if (start) begin
            held_bq    = bq;
            inner_left = {b[3:0], 8'h00};
            outer_left = '0;
            img_tag    = '0;
            desc_left  = '0;
            ent_cnt    = '0;
            ent_buf    = '0;
            cur_ts     = '0;
            cur_net    = '0;
            walk_phase = W_BQ_LEN_LO;
        end else begin
            case (walk_phase)
                W_BQ_LEN_LO: begin
                    outer_left = inner_left | {4'h0, b};
                    inner_left = '0;
                    desc_step  = D_TAG;
                    walk_phase = (outer_left != 12'd0) ? W_BQ_DESC : W_TS_LEN_HI;
                end
                W_BQ_DESC: begin
                    walk_descriptor_byte(b, 1'b0, outer_left);
                    if (outer_left == 12'd0)
                        walk_phase = W_TS_LEN_HI;
                end
                W_TS_LEN_HI: begin
                    inner_left = {b[3:0], 8'h00};
                    walk_phase = W_TS_LEN_LO;
                end
                W_TS_LEN_LO: begin
                    outer_left = inner_left | {4'h0, b};
                    inner_left = '0;
                    ent_cnt    = '0;
                    ent_buf    = '0;
                    walk_phase = (outer_left != 12'd0) ? W_TS_HDR : W_DONE;
                end
                W_TS_HDR: begin
                    outer_left = outer_left - 12'd1;
                    ent_buf    = {ent_buf[39:0], b};
                    ent_cnt    = ent_cnt + 3'd1;
                    if (ent_cnt >= 3'd6) begin
                        cur_ts     = ent_buf[47:32];
                        cur_net    = ent_buf[31:16];
                        inner_left = ent_buf[11:0];
                        ent_cnt    = '0;
                        ent_buf    = '0;
                        if (inner_left != 12'd0) begin
                            desc_step  = D_TAG;
                            walk_phase = W_TD_DESC;
                        end
                    end
                    if (outer_left == 12'd0)
                        walk_phase = W_DONE;
                end
                W_TD_DESC: begin
                    outer_left = outer_left - 12'd1;
                    walk_descriptor_byte(b, 1'b1, inner_left);
                    if (inner_left == 12'd0) begin
                        ent_cnt    = '0;
                        ent_buf    = '0;
                        walk_phase = W_TS_HDR;
                    end
                    if (outer_left == 12'd0)
                        walk_phase = W_DONE;
                end
                default: ;
            endcase
        end
    endtask

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_cnt++;
        end
    endfunction

    task automatic check_service(input bsl_result_t got);
        bsl_result_t want;
        if (pending_services.size() == 0) begin
            $error("service entry with none expected: %h", got);
            fail_cnt++;
        end else begin
            want = pending_services.pop_front();
            cmp_field("out_bouquet", want.out_bouquet, got.out_bouquet);
            cmp_field("transport_stream", want.transport_stream, got.transport_stream);
            cmp_field("network", want.network, got.network);
            cmp_field("service", want.service, got.service);
            cmp_field("service_kind", 16'(want.service_kind), 16'(got.service_kind));
            cmp_field("kind_known", 16'(want.kind_known), 16'(got.kind_known));
        end
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_wait != 0) begin
                s_tvalid <= 1'b0;
                src_wait <= src_wait - 1;
            end else if (byte_feed.size() != 0) begin
                next_item = byte_feed.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= {next_item.bouquet, next_item.sbyte};
                s_tuser   <= next_item.start;
                src_wait  <= src_calm ? 0 : int'($urandom_range(0, 15));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            sink_draw = sink_calm ? 0 : int'($urandom_range(0, 15));
            sink_wait <= sink_draw;
            m_tready  <= (sink_draw == 0);
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_tready  <= (sink_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // results are checked before the item taken on the same edge is predicted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_service(bsl_result_t'({m_tuser, m_tdata}));
            if (s_tvalid && s_tready)
                walk_section_byte(s_tdata[7:0], s_tuser, s_tdata[23:8]);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_item(input logic [7:0] b, input logic start, input logic [15:0] bq);
        feed_item_t it;
        it.sbyte   = b;
        it.start   = start;
        it.bouquet = bq;
        byte_feed.push_back(it);
    endtask

    task automatic put_len(input int pos, input int len);
        sec_buf[pos]     = {4'($urandom_range(0, 15)), 4'(len >> 8)};
        sec_buf[pos + 1] = 8'(len);
    endtask

    task automatic add_descriptor(input logic in_ts);
        int unit;
        int body;
        logic [7:0] tag;
        unit = in_ts ? 3 : 6;
        if ($urandom_range(0, 9) < 6)
            tag = in_ts ? SERVICE_LIST_TAG : list_tag;
        else
            tag = 8'($urandom_range(0, 255));
        body = unit * int'($urandom_range(0, 4));
        if ($urandom_range(0, 3) == 0)
            body = body + int'($urandom_range(1, unit - 1));
        sec_buf.push_back(tag);
        sec_buf.push_back(8'(body));
        repeat (body) sec_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_section();
        int tl_pos;
        int hdr_pos;
        sec_buf.delete();
        sec_buf.push_back(8'h00);
        sec_buf.push_back(8'h00);
        repeat ($urandom_range(0, 3)) add_descriptor(1'b0);
        put_len(0, sec_buf.size() - 2);
        tl_pos = sec_buf.size();
        sec_buf.push_back(8'h00);
        sec_buf.push_back(8'h00);
        repeat ($urandom_range(0, 4)) begin
            repeat (4) sec_buf.push_back(8'($urandom_range(0, 255)));
            hdr_pos = sec_buf.size();
            sec_buf.push_back(8'h00);
            sec_buf.push_back(8'h00);
            repeat ($urandom_range(0, 3)) add_descriptor(1'b1);
            put_len(hdr_pos, sec_buf.size() - hdr_pos - 2);
        end
        put_len(tl_pos, sec_buf.size() - tl_pos - 2);
    endtask

    task automatic feed_section();
        int keep;
        logic [15:0] bq;
        build_section();
        case ($urandom_range(0, 9))
            0: sec_buf[$urandom_range(0, sec_buf.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
                // cut short, so the next start lands mid-parse
                keep = int'($urandom_range(1, sec_buf.size()));
                while (sec_buf.size() > keep) void'(sec_buf.pop_back());
            end
            2: begin
                repeat (8)
                    queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                               16'($urandom));
            end
            default: ;
        endcase
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
        bq = 16'($urandom);
        foreach (sec_buf[i])
            queue_item(sec_buf[i], i == 0, (i == 0) ? bq : 16'($urandom));
        phase_items = phase_items + sec_buf.size();
        repeat ($urandom_range(0, 2)) queue_item(8'($urandom), 1'b0, 16'($urandom));
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (byte_feed.size() != 0 || s_tvalid || pending_services.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_tag(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        list_tag = v;
    endtask

    initial begin
        tag_plan = '{8'h00, 8'hFF, SERVICE_LIST_TAG, 8'h00, PRIVATE_TAG_RESET};
        tag_plan[3] = 8'($urandom_range(1, 254));
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (INTRO_BYTES[i])
            queue_item(INTRO_BYTES[i], i == 1, (i == 1) ? 16'hFFFF : 16'h0000);
        wait_idle();

        foreach (tag_plan[p]) begin
            write_tag(tag_plan[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) feed_section();
            // empty section so that the parser rests in its done state
            queue_item(8'h00, 1'b1, 16'($urandom));
            repeat (3) queue_item(8'h00, 1'b0, 16'($urandom));
            wait_idle();
        end

        repeat (8) @(negedge aclk);
        if (fail_cnt == 0 && pending_services.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[bat_service_list_parser_top.f]
rtl/core/bsl_pkg.sv
rtl/core/bsl_parse.sv
rtl/core/bsl_outbuf.sv
rtl/core/bat_service_list_parser_top.sv
rtl/core/bsl_checker.sv
tb/bat_service_list_parser_top_tb.sv
